// ===== rtl/ptsu_pkg.sv =====
// shared types and constants of the priority thread scheduler
`timescale 1ns / 1ps

package ptsu_pkg;

  // operation codes of an input beat
  typedef enum logic [2:0] {
    OP_TICK     = 3'd0,
    OP_SCHEDULE = 3'd1,
    OP_SLEEP    = 3'd2,
    OP_WAIT     = 3'd3,
    OP_SIGNAL   = 3'd4,
    OP_INIT     = 3'd5
  } op_e;

  // sequencer states, one-hot
  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_TICK = 5'b00010,
    S_SCAN = 5'b00100,
    S_WAKE = 5'b01000,
    S_FIN  = 5'b10000
  } state_e;

  typedef logic [2:0]         thread_t;   // thread number on the ports
  typedef logic [2:0]         blk_tag_t;  // 0 unblocked, s+1 blocked on semaphore s
  typedef logic [7:0]         prio_t;
  typedef logic [31:0]        sleep_t;
  typedef logic signed [15:0] sem_val_t;

  localparam prio_t    NEVER_PRIORITY = 8'd255;
  localparam sem_val_t SEM_MAX        = 16'sh7fff;
  localparam sem_val_t SEM_MIN        = 16'sh8000;
  localparam int       SEM_ID_SLOTS   = 4;  // addressable by the 2-bit semaphore id

endpackage

// ===== rtl/priority_thread_scheduler_unit.sv =====
// top level of the priority round-robin thread scheduler with counting semaphores
`timescale 1ns / 1ps

// channel   direction  handshake                 payload
// ------    ---------  ------------------------  -------------------------------------------
// in        to block   in_valid_i / in_stall_o   op_i, sem_id_i, sleep_ms_i, init_value_i
// out       from block out_valid_o / out_stall_i running_thread_o, none_ready_o,
//                                                caller_blocked_o, woke_valid_o,
//                                                woke_thread_o, sem_value_o
// cfg       to block   cfg_we_i                  cfg_index_i, cfg_wdata_i (thread priorities)
//
// one beat at a time: accept, then the work, then the load of the output register
// tick: one sleep counter per cycle through the shared decrementer
// schedule, sleep, blocking wait: one thread per cycle through compare
// signal that may wake: ring search for a waiter; init, other waits and signals go straight to the load
// a result held by out_stall_i delays the next load, and no new beat is taken meanwhile
// reset clears all thread and semaphore state at once, no clearing pass

module priority_thread_scheduler_unit #(
  parameter int NUM_THREADS    = 8,
  parameter int NUM_SEMAPHORES = 4
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  // configuration writes
  input  logic                cfg_we_i,
  input  logic [2:0]          cfg_index_i,
  input  logic [7:0]          cfg_wdata_i,
  // input channel
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [2:0]          op_i,
  input  logic [1:0]          sem_id_i,
  input  logic [31:0]         sleep_ms_i,
  input  logic signed [15:0]  init_value_i,
  // output channel
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [2:0]          running_thread_o,
  output logic                none_ready_o,
  output logic                caller_blocked_o,
  output logic                woke_valid_o,
  output logic [2:0]          woke_thread_o,
  output logic signed [15:0]  sem_value_o
);

  localparam int TW        = $clog2(NUM_THREADS);
  localparam int SEM_DEPTH = (NUM_SEMAPHORES < ptsu_pkg::SEM_ID_SLOTS) ?
                             NUM_SEMAPHORES : ptsu_pkg::SEM_ID_SLOTS;
  localparam int SW        = (SEM_DEPTH > 1) ? $clog2(SEM_DEPTH) : 1;
  localparam logic [TW-1:0] LAST_THREAD = TW'(NUM_THREADS - 1);

  typedef logic [TW-1:0] tidx_t;

  function automatic tidx_t ring_next(input tidx_t t);
    return (t == LAST_THREAD) ? '0 : t + tidx_t'(1);
  endfunction

  // thread and semaphore state
  ptsu_pkg::prio_t    pri_q   [NUM_THREADS];
  ptsu_pkg::sleep_t   sleep_q [NUM_THREADS];
  ptsu_pkg::blk_tag_t blk_q   [NUM_THREADS];
  ptsu_pkg::sem_val_t sem_q   [SEM_DEPTH];
  tidx_t              cur_q;

  // sequencer
  ptsu_pkg::state_e   state_q, state_d;
  tidx_t              idx_q;        // thread under the shared unit this cycle
  ptsu_pkg::prio_t    best_pri_q;
  tidx_t              best_thr_q;
  logic               found_q;
  ptsu_pkg::blk_tag_t wake_tag_q;   // tag searched by a signal

  // result being built
  logic               r_none_q;
  logic               r_blk_q;
  logic               r_woke_q;
  tidx_t              r_woke_thr_q;
  ptsu_pkg::sem_val_t r_sval_q;

  // output register
  logic               out_valid_q;
  ptsu_pkg::thread_t  o_run_q;
  logic               o_none_q;
  logic               o_blk_q;
  logic               o_woke_q;
  ptsu_pkg::thread_t  o_woke_thr_q;
  ptsu_pkg::sem_val_t o_sval_q;

  logic               acc_in;
  logic               out_load;
  logic               sem_ok;
  logic [SW-1:0]      sem_idx;
  ptsu_pkg::sem_val_t sem_rd;
  ptsu_pkg::sem_val_t sem_dec;
  ptsu_pkg::sem_val_t sem_inc;
  ptsu_pkg::blk_tag_t sem_tag;
  logic               cand_ready;   // shared compare: thread idx_q is ready and beats the best so far
  logic               idx_is_cur;
  tidx_t              cur_next;
  ptsu_pkg::op_e      op;

  assign in_stall_o = (state_q != ptsu_pkg::S_IDLE);
  assign acc_in     = in_valid_i && !in_stall_o;
  assign out_load   = (state_q == ptsu_pkg::S_FIN) && (!out_valid_q || !out_stall_i);
  assign op         = ptsu_pkg::op_e'(op_i);

  always_comb begin
    sem_ok     = ({30'd0, sem_id_i} < 32'(NUM_SEMAPHORES));
    sem_idx    = sem_id_i[SW-1:0];
    sem_rd     = sem_q[sem_idx];
    // saturating step of the semaphore count
    sem_dec    = (sem_rd == ptsu_pkg::SEM_MIN) ? sem_rd : sem_rd - 16'sd1;
    sem_inc    = (sem_rd == ptsu_pkg::SEM_MAX) ? sem_rd : sem_rd + 16'sd1;
    sem_tag    = ptsu_pkg::blk_tag_t'({1'b0, sem_id_i}) + ptsu_pkg::blk_tag_t'(1);
    cand_ready = (pri_q[idx_q] < best_pri_q) && (sleep_q[idx_q] == '0) &&
                 (blk_q[idx_q] == '0);
    idx_is_cur = (idx_q == cur_q);
    cur_next   = ring_next(cur_q);
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ptsu_pkg::S_IDLE: begin
        if (acc_in) begin
          case (op)
            ptsu_pkg::OP_TICK:                         state_d = ptsu_pkg::S_TICK;
            ptsu_pkg::OP_SCHEDULE, ptsu_pkg::OP_SLEEP: state_d = ptsu_pkg::S_SCAN;
            ptsu_pkg::OP_WAIT: begin
              state_d = (sem_ok && sem_dec[15]) ? ptsu_pkg::S_SCAN : ptsu_pkg::S_FIN;
            end
            ptsu_pkg::OP_SIGNAL: begin
              state_d = (sem_ok && (sem_inc <= 16'sd0)) ? ptsu_pkg::S_WAKE
                                                         : ptsu_pkg::S_FIN;
            end
            default:                                   state_d = ptsu_pkg::S_FIN;
          endcase
        end
      end
      ptsu_pkg::S_TICK: begin
        if (idx_q == LAST_THREAD) state_d = ptsu_pkg::S_FIN;
      end
      ptsu_pkg::S_SCAN: begin
        if (idx_is_cur) state_d = ptsu_pkg::S_FIN;
      end
      ptsu_pkg::S_WAKE: begin
        if (idx_is_cur || (blk_q[idx_q] == wake_tag_q)) state_d = ptsu_pkg::S_FIN;
      end
      ptsu_pkg::S_FIN: begin
        if (out_load) state_d = ptsu_pkg::S_IDLE;
      end
      default: state_d = ptsu_pkg::S_IDLE;
    endcase
  end

  // priorities come from the configuration port only
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_THREADS; i++) pri_q[i] <= '0;
    end else if (cfg_we_i && ({29'd0, cfg_index_i} < 32'(NUM_THREADS))) begin
      pri_q[cfg_index_i[TW-1:0]] <= cfg_wdata_i;
    end
  end

  // sequencer and thread state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ptsu_pkg::S_IDLE;
      cur_q        <= '0;
      idx_q        <= '0;
      found_q      <= 1'b0;
      best_pri_q   <= ptsu_pkg::NEVER_PRIORITY;
      best_thr_q   <= '0;
      wake_tag_q   <= '0;
      r_none_q     <= 1'b0;
      r_blk_q      <= 1'b0;
      r_woke_q     <= 1'b0;
      r_woke_thr_q <= '0;
      r_sval_q     <= '0;
      for (int i = 0; i < NUM_THREADS; i++) begin
        sleep_q[i] <= '0;
        blk_q[i]   <= '0;
      end
      for (int s = 0; s < SEM_DEPTH; s++) sem_q[s] <= '0;
    end else begin
      state_q <= state_d;
      case (state_q)
        ptsu_pkg::S_IDLE: begin
          if (acc_in) begin
            idx_q        <= (op == ptsu_pkg::OP_TICK) ? '0 : cur_next;
            best_pri_q   <= ptsu_pkg::NEVER_PRIORITY;
            best_thr_q   <= cur_q;
            found_q      <= 1'b0;
            wake_tag_q   <= sem_tag;
            r_none_q     <= 1'b0;
            r_blk_q      <= 1'b0;
            r_woke_q     <= 1'b0;
            r_woke_thr_q <= '0;
            r_sval_q     <= '0;
            case (op)
              ptsu_pkg::OP_SLEEP: sleep_q[cur_q] <= sleep_ms_i;
              ptsu_pkg::OP_WAIT: begin
                if (sem_ok) begin
                  sem_q[sem_idx] <= sem_dec;
                  r_sval_q       <= sem_dec;
                  if (sem_dec[15]) begin
                    blk_q[cur_q] <= sem_tag;
                    r_blk_q      <= 1'b1;
                  end
                end
              end
              ptsu_pkg::OP_SIGNAL: begin
                if (sem_ok) begin
                  sem_q[sem_idx] <= sem_inc;
                  r_sval_q       <= sem_inc;
                end
              end
              ptsu_pkg::OP_INIT: begin
                if (sem_ok) begin
                  sem_q[sem_idx] <= init_value_i;
                  r_sval_q       <= init_value_i;
                end
              end
              default: ;
            endcase
          end
        end
        ptsu_pkg::S_TICK: begin
          // shared decrementer walks the sleep counters
          if (sleep_q[idx_q] != '0) sleep_q[idx_q] <= sleep_q[idx_q] - 32'd1;
          idx_q <= ring_next(idx_q);
        end
        ptsu_pkg::S_SCAN: begin
          if (cand_ready) begin
            best_pri_q <= pri_q[idx_q];
            best_thr_q <= idx_q;
            found_q    <= 1'b1;
          end
          if (idx_is_cur) begin
            // current thread was looked at last
            cur_q    <= cand_ready ? idx_q : best_thr_q;
            r_none_q <= !(found_q || cand_ready);
          end else begin
            idx_q <= ring_next(idx_q);
          end
        end
        ptsu_pkg::S_WAKE: begin
          if (blk_q[idx_q] == wake_tag_q) begin
            blk_q[idx_q] <= '0;
            r_woke_q     <= 1'b1;
            r_woke_thr_q <= idx_q;
          end else begin
            idx_q <= ring_next(idx_q);
          end
        end
        default: ;
      endcase
    end
  end

  // output register, parts the two channels
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      o_run_q      <= ptsu_pkg::thread_t'(cur_q);
      o_none_q     <= r_none_q;
      o_blk_q      <= r_blk_q;
      o_woke_q     <= r_woke_q;
      o_woke_thr_q <= ptsu_pkg::thread_t'(r_woke_thr_q);
      o_sval_q     <= r_sval_q;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign running_thread_o = o_run_q;
  assign none_ready_o     = o_none_q;
  assign caller_blocked_o = o_blk_q;
  assign woke_valid_o     = o_woke_q;
  assign woke_thread_o    = o_woke_thr_q;
  assign sem_value_o      = o_sval_q;

endmodule

// ===== rtl/ptsu_checker.sv =====
// port-level checker of the thread scheduler and its bind
`timescale 1ns / 1ps

module ptsu_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_stall_o,
  input logic                out_valid_o,
  input logic                out_stall_i,
  input logic [2:0]          running_thread_o,
  input logic                none_ready_o,
  input logic                caller_blocked_o,
  input logic                woke_valid_o,
  input logic [2:0]          woke_thread_o,
  input logic signed [15:0]  sem_value_o
);

  ptsu_pkg::thread_t no_thread;
  assign no_thread = '0;

  // an accepted beat makes the block busy in the next cycle
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("input taken right after an accepted beat");

  // a stalled result stays valid, with its running thread and semaphore value unchanged
  a_result_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=>
      (out_valid_o && $stable(running_thread_o) && $stable(sem_value_o)))
    else $error("stalled result changed");

  // no woken thread is reported without a wake
  a_woke_thread_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !woke_valid_o) |-> (woke_thread_o == no_thread))
    else $error("woke thread set without a wake");

  // a wake comes from a signal only, which neither blocks nor reschedules
  a_wake_alone: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && woke_valid_o) |-> (!caller_blocked_o && !none_ready_o))
    else $error("wake reported together with block or schedule flags");

endmodule

bind priority_thread_scheduler_unit ptsu_checker u_ptsu_checker (.*);
